// ----- design/skac_pkg.sv -----
`default_nettype none
package skac_pkg;

  // Fixed-point geometry
  localparam int SAMPLE_BITS    = 24;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_SIZE       = 1 << LOG_TABLE_BITS;
  localparam int MAG_W          = SAMPLE_BITS;
  localparam int POS_W          = $clog2(SAMPLE_BITS);
  localparam int NORM_STEPS     = $clog2(SAMPLE_BITS);
  localparam int EXP_STEPS      = 16;
  localparam int STEP_W         = 4;
  localparam int L2_W           = POS_W + 18;
  localparam int DBP_W          = L2_W + 20;

  // dB per octave (Q16 scaled) and octaves per dB (Q24 scaled)
  localparam int DB_PER_LOG2 = 394566;
  localparam int LOG2_PER_DB = 2786635;

  // Config register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_KNEE_W    = 3'd1;
  localparam logic [2:0] CFG_KNEE_INV  = 3'd2;
  localparam logic [2:0] CFG_SLOPE     = 3'd3;
  localparam logic [2:0] CFG_MAKEUP    = 3'd4;
  localparam logic [2:0] CFG_ATTACK    = 3'd5;
  localparam logic [2:0] CFG_RELEASE   = 3'd6;

  typedef struct packed {
    logic [15:0] threshold_level;
    logic [12:0] knee_width;
    logic [15:0] knee_inverse;
    logic [15:0] slope;
    logic [13:0] makeup_level;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
  } cfg_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ENV,
    DP_NORM,
    DP_LOG,
    DP_DB,
    DP_RED_T,
    DP_RED_P,
    DP_RED_1,
    DP_RED_2,
    DP_GAIN,
    DP_E2,
    DP_EXP,
    DP_PROD,
    DP_FINAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STEP_W-1:0]   idx;
  } dp_cmd_t;

  typedef struct packed {
    logic env_zero;
  } dp_status_t;

  typedef logic [15:0] log_tab_t [LOG_SIZE];
  typedef logic [31:0] exp_tab_t [EXP_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bit_v;
    n     = n_in;
    root  = 64'd0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 64'd0) begin
      if (n >= root + bit_v) begin
        n    = n - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  // log2(1 + i/LOG_SIZE) in Q0.16 by repeated squaring, truncated
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] m;
    logic [15:0] r;
    for (int i = 0; i < LOG_SIZE; i++) begin
      m = 64'(LOG_SIZE + i) << (30 - LOG_TABLE_BITS);
      r = 16'd0;
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r = r | (16'd1 << k);
        end
      end
      tab[i] = r;
    end
    return tab;
  endfunction

  // 2^(2^-(k+1)) in Q2.30 by repeated square roots
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] v;
    v      = isqrt64(64'd2 << 60);
    tab[0] = v[31:0];
    for (int k = 1; k < EXP_STEPS; k++) begin
      v      = isqrt64(v << 30);
      tab[k] = v[31:0];
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ----- design/skac_cfg_regs.sv -----
`default_nettype none
module skac_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i,
  output skac_pkg::cfg_t    cfg_o
);

  skac_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode, upper bits dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        skac_pkg::CFG_THRESHOLD: cfg_d.threshold_level = cfg_data_i;
        skac_pkg::CFG_KNEE_W:    cfg_d.knee_width      = cfg_data_i[12:0];
        skac_pkg::CFG_KNEE_INV:  cfg_d.knee_inverse    = cfg_data_i;
        skac_pkg::CFG_SLOPE:     cfg_d.slope           = cfg_data_i;
        skac_pkg::CFG_MAKEUP:    cfg_d.makeup_level    = cfg_data_i[13:0];
        skac_pkg::CFG_ATTACK:    cfg_d.attack_coeff    = cfg_data_i;
        skac_pkg::CFG_RELEASE:   cfg_d.release_coeff   = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_level <= 16'hEC00;
      cfg_q.knee_width      <= 13'd1536;
      cfg_q.knee_inverse    <= 16'd43690;
      cfg_q.slope           <= 16'd49152;
      cfg_q.makeup_level    <= 14'd0;
      cfg_q.attack_coeff    <= 16'd64880;
      cfg_q.release_coeff   <= 16'd65470;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/skac_dp.sv -----
`default_nettype none
module skac_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  skac_pkg::dp_cmd_t                       cmd_i,
  input  skac_pkg::cfg_t                          cfg_i,
  input  wire logic [skac_pkg::SAMPLE_BITS-1:0]   sample_in_i,
  input  wire logic                               block_end_in_i,
  output skac_pkg::dp_status_t                    status_o,
  output logic [skac_pkg::SAMPLE_BITS-1:0]        sample_out_o,
  output logic [15:0]                             gain_meter_o,
  output logic                                    block_end_out_o
);

  localparam int SB    = skac_pkg::SAMPLE_BITS;
  localparam int MW    = skac_pkg::MAG_W;
  localparam int PW    = skac_pkg::POS_W;
  localparam int LB    = skac_pkg::LOG_TABLE_BITS;
  localparam int L2W   = skac_pkg::L2_W;
  localparam int DBW   = skac_pkg::DBP_W;
  localparam int PADW  = MW - 1 + LB;
  localparam int PRW   = MW + 32;

  localparam logic signed [DBW-1:0] DB_HALF = DBW'(64'd1 << 23);
  localparam logic signed [DBW-1:0] DB_MAXW = DBW'(32767);
  localparam logic signed [DBW-1:0] DB_MINW = -DBW'(32768);
  localparam logic signed [DBW-1:0] DB_K    = DBW'(skac_pkg::DB_PER_LOG2);
  localparam logic signed [39:0]    E2_K    = 40'(skac_pkg::LOG2_PER_DB);
  localparam logic signed [19:0]    G_MAXW  = 20'sd32767;
  localparam logic signed [19:0]    G_MINW  = -20'sd32768;
  localparam logic [PRW-1:0]        FULL_W  = PRW'(1) << (SB - 1);
  localparam logic [SB-1:0]         FULL_S  = SB'(1) << (SB - 1);

  // item and working registers
  logic                     sign_q, bend_q;
  logic [MW-1:0]            mag_q, env_q, norm_q;
  logic [PW-1:0]            pos_q;
  logic signed [DBW-1:0]    dbprod_q;
  logic signed [15:0]       db_q;
  logic signed [35:0]       tprod_q;
  logic                     above_q, knee_q;
  logic [16:0]              prog_q;
  logic signed [29:0]       t_q;
  logic signed [15:0]       gain_q;
  logic signed [23:0]       e2_q;
  logic [31:0]              m_q;
  logic [PRW-1:0]           prod_q;
  logic [SB-1:0]            sample_out_q;
  logic [15:0]              gain_meter_q;
  logic                     bend_out_q;

  assign status_o.env_zero = (env_q == '0);
  assign sample_out_o      = sample_out_q;
  assign gain_meter_o      = gain_meter_q;
  assign block_end_out_o   = bend_out_q;

  // sample magnitude
  logic [MW-1:0] mag_in;
  assign mag_in = sample_in_i[SB-1] ? MW'(~sample_in_i + 1'b1) : MW'(sample_in_i);

  // envelope follower
  logic [15:0]      coeff;
  logic             env_ge;
  logic [MW-1:0]    env_diff, env_step, env_new;
  logic [MW+15:0]   env_prod;
  always_comb begin
    env_ge   = (env_q >= mag_q);
    coeff    = (mag_q > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
    env_diff = env_ge ? (env_q - mag_q) : (mag_q - env_q);
    env_prod = (MW+16)'(env_diff) * (MW+16)'(coeff);
    env_step = env_prod[MW+15:16];
    env_new  = env_ge ? (mag_q + env_step) : (mag_q - env_step);
  end

  // normalize step: shift out leading zeros in halving chunks
  logic [PW-1:0] nshift;
  logic          ntop_zero;
  always_comb begin
    nshift    = PW'(1) << (PW'(skac_pkg::NORM_STEPS - 1) - PW'(cmd_i.idx));
    ntop_zero = ((norm_q >> (MW - int'(nshift))) == '0);
  end

  // log2 and dB conversion
  logic [PADW-1:0]        pad;
  logic [LB-1:0]          tab_idx;
  logic [15:0]            tab_val;
  logic signed [L2W-1:0]  pexp, l2;
  logic signed [DBW-1:0]  dbprod, db_rnd;
  logic signed [15:0]     db_sat;
  always_comb begin
    pad     = {norm_q[MW-2:0], {LB{1'b0}}};
    tab_idx = pad[PADW-1 -: LB];
    tab_val = skac_pkg::LOG_TAB[tab_idx];
    pexp    = $signed(L2W'(pos_q)) - $signed(L2W'(MW - 1));
    l2      = (pexp <<< 16) + $signed(L2W'(tab_val));
    dbprod  = DBW'(l2) * DB_K;
    db_rnd  = (dbprod_q + DB_HALF) >>> 24;
    if (env_q == '0)            db_sat = -16'sd32768;
    else if (db_rnd > DB_MAXW)  db_sat = 16'sd32767;
    else if (db_rnd < DB_MINW)  db_sat = -16'sd32768;
    else                        db_sat = db_rnd[15:0];
  end

  // gain reduction curve
  logic signed [17:0] thr_w, half_w, start_w, end_w, db_w, excess, kd, slope_w, kinv_w, prog_s;
  logic signed [35:0] tprod, pprod, pshift;
  logic [16:0]        prog_n;
  logic signed [29:0] tk_src, t_next;
  logic signed [47:0] tk_prod, tk_shift;
  logic signed [19:0] red, gsum;
  logic signed [15:0] gain_n;
  always_comb begin
    thr_w   = 18'($signed(cfg_i.threshold_level));
    half_w  = $signed({6'd0, cfg_i.knee_width[12:1]});
    start_w = thr_w - half_w;
    end_w   = thr_w + half_w;
    db_w    = 18'(db_q);
    excess  = db_w - thr_w;
    slope_w = $signed({2'b00, cfg_i.slope});
    kinv_w  = $signed({2'b00, cfg_i.knee_inverse});
    tprod   = 36'(excess) * 36'(slope_w);
    kd      = db_w - start_w;
    pprod   = 36'(kd) * 36'(kinv_w);
    pshift  = pprod >>> 10;
    prog_n  = (pshift > 36'sd65536) ? 17'd65536 : pshift[16:0];
    prog_s  = $signed({1'b0, prog_q});
    // knee excess is bounded by half the knee, so 30 bits hold the product
    tk_src  = (cmd_i.op == skac_pkg::DP_RED_1) ? $signed(tprod_q[29:0]) : t_q;
    tk_prod = 48'(tk_src) * 48'(prog_s);
    tk_shift = tk_prod >>> 16;
    t_next  = tk_shift[29:0];
    if (above_q)     red = 20'(tprod_q >>> 16);
    else if (knee_q) red = 20'(t_q >>> 16);
    else             red = 20'sd0;
    gsum    = 20'($signed(cfg_i.makeup_level)) - red;
    if (gsum > G_MAXW)      gain_n = 16'sd32767;
    else if (gsum < G_MINW) gain_n = -16'sd32768;
    else                    gain_n = gsum[15:0];
  end

  // exponent and linear gain
  logic signed [39:0]  e2prod, e2shift;
  logic [63:0]         m_prod;
  logic signed [7:0]   ip;
  logic signed [8:0]   sh;
  logic [PRW-1:0]      shifted;
  logic [SB-1:0]       psat, yout;
  always_comb begin
    e2prod  = 40'(gain_q) * E2_K;
    e2shift = e2prod >>> 16;
    m_prod  = 64'(m_q) * 64'(skac_pkg::EXP_TAB[cmd_i.idx]);
    ip      = e2_q[23:16];
    sh      = 9'sd30 - 9'(ip);
    shifted = (sh >= 9'sd63) ? '0 : (prod_q >> sh[5:0]);
    psat    = (shifted > FULL_W) ? FULL_S : shifted[SB-1:0];
    if (sign_q)             yout = ~psat + 1'b1;
    else if (psat == FULL_S) yout = FULL_S - 1'b1;
    else                    yout = psat;
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (cmd_i.op == skac_pkg::DP_ENV) begin
      env_q <= env_new;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      skac_pkg::DP_LOAD: begin
        sign_q <= sample_in_i[SB-1];
        mag_q  <= mag_in;
        bend_q <= block_end_in_i;
      end
      skac_pkg::DP_ENV: begin
        norm_q <= env_new;
        pos_q  <= PW'(MW - 1);
      end
      skac_pkg::DP_NORM: begin
        if (ntop_zero) begin
          norm_q <= norm_q << nshift;
          pos_q  <= pos_q - nshift;
        end
      end
      skac_pkg::DP_LOG:   dbprod_q <= dbprod;
      skac_pkg::DP_DB:    db_q     <= db_sat;
      skac_pkg::DP_RED_T: begin
        tprod_q <= tprod;
        above_q <= (db_w > end_w);
        knee_q  <= (db_w > start_w);
      end
      skac_pkg::DP_RED_P: prog_q <= prog_n;
      skac_pkg::DP_RED_1: t_q    <= t_next;
      skac_pkg::DP_RED_2: t_q    <= t_next;
      skac_pkg::DP_GAIN:  gain_q <= gain_n;
      skac_pkg::DP_E2: begin
        e2_q <= e2shift[23:0];
        m_q  <= 32'd1 << 30;
      end
      skac_pkg::DP_EXP: begin
        if (e2_q[4'd15 - cmd_i.idx]) m_q <= m_prod[61:30];
      end
      skac_pkg::DP_PROD:  prod_q <= PRW'(mag_q) * PRW'(m_q);
      skac_pkg::DP_FINAL: begin
        sample_out_q <= yout;
        gain_meter_q <= gain_q;
        bend_out_q   <= bend_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/skac_ctrl.sv -----
`default_nettype none
module skac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  skac_pkg::dp_status_t      status_i,
  output skac_pkg::dp_cmd_t         cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ENV   = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_LOG   = 4'd3;
  localparam logic [3:0] ST_DB    = 4'd4;
  localparam logic [3:0] ST_RED_T = 4'd5;
  localparam logic [3:0] ST_RED_P = 4'd6;
  localparam logic [3:0] ST_RED_1 = 4'd7;
  localparam logic [3:0] ST_RED_2 = 4'd8;
  localparam logic [3:0] ST_GAIN  = 4'd9;
  localparam logic [3:0] ST_E2    = 4'd10;
  localparam logic [3:0] ST_EXP   = 4'd11;
  localparam logic [3:0] ST_PROD  = 4'd12;
  localparam logic [3:0] ST_FINAL = 4'd13;

  localparam int SW = skac_pkg::STEP_W;
  localparam logic [SW-1:0] NORM_LAST = SW'(skac_pkg::NORM_STEPS - 1);
  localparam logic [SW-1:0] EXP_LAST  = SW'(skac_pkg::EXP_STEPS - 1);

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic          ovalid_q, ovalid_d;
  logic          slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign slot_free   = !ovalid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovalid_d   = ovalid_q && out_stall_i;
    cmd_o.op   = skac_pkg::DP_NOP;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = skac_pkg::DP_LOAD;
          state_d  = ST_ENV;
        end
      end
      ST_ENV: begin
        cmd_o.op = skac_pkg::DP_ENV;
        cnt_d    = '0;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        if (status_i.env_zero) begin
          state_d = ST_LOG;
        end else begin
          cmd_o.op = skac_pkg::DP_NORM;
          cnt_d    = cnt_q + 1'b1;
          if (cnt_q == NORM_LAST) state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        cmd_o.op = skac_pkg::DP_LOG;
        state_d  = ST_DB;
      end
      ST_DB: begin
        cmd_o.op = skac_pkg::DP_DB;
        state_d  = ST_RED_T;
      end
      ST_RED_T: begin
        cmd_o.op = skac_pkg::DP_RED_T;
        state_d  = ST_RED_P;
      end
      ST_RED_P: begin
        cmd_o.op = skac_pkg::DP_RED_P;
        state_d  = ST_RED_1;
      end
      ST_RED_1: begin
        cmd_o.op = skac_pkg::DP_RED_1;
        state_d  = ST_RED_2;
      end
      ST_RED_2: begin
        cmd_o.op = skac_pkg::DP_RED_2;
        state_d  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.op = skac_pkg::DP_GAIN;
        state_d  = ST_E2;
      end
      ST_E2: begin
        cmd_o.op = skac_pkg::DP_E2;
        cnt_d    = '0;
        state_d  = ST_EXP;
      end
      ST_EXP: begin
        cmd_o.op = skac_pkg::DP_EXP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == EXP_LAST) state_d = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.op = skac_pkg::DP_PROD;
        state_d  = ST_FINAL;
      end
      ST_FINAL: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd_o.op = skac_pkg::DP_FINAL;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/soft_knee_audio_compressor.sv -----
`default_nettype none
// Soft-knee audio compressor. Each accepted word carries one signed Q1.23 sample;
// one result word follows with the gained sample, the applied gain in Q8.8 dB and
// the block-end marker. One word is processed at a time: the sequencer steps through
// capture, envelope update, five normalize steps of the log2 search (skipped when
// the envelope is zero), eight log/curve/gain steps, sixteen exponent steps through
// one 32x32 multiplier, a final multiply and the output load before the next word
// can be taken. A finished word waits in the output register while the next
// sample is taken; the sequencer holds its last step only if that register is
// still occupied. Configuration must be written through the index/data port only
// between words, while no word is in flight; the block itself does not enforce
// this. The configuration port is always ready.
module soft_knee_audio_compressor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [skac_pkg::SAMPLE_BITS-1:0]   sample_in_i,
  input  wire logic                               block_end_in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [skac_pkg::SAMPLE_BITS-1:0]        sample_out_o,
  output logic [15:0]                             gain_meter_o,
  output logic                                    block_end_out_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [2:0]                         cfg_index_i,
  input  wire logic [15:0]                        cfg_data_i
);

  skac_pkg::cfg_t       cfg;
  skac_pkg::dp_cmd_t    cmd;
  skac_pkg::dp_status_t status;

  skac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  skac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  skac_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .sample_in_i     (sample_in_i),
    .block_end_in_i  (block_end_in_i),
    .status_o        (status),
    .sample_out_o    (sample_out_o),
    .gain_meter_o    (gain_meter_o),
    .block_end_out_o (block_end_out_o)
  );

endmodule
`default_nettype wire

// ----- design/skac_checker.sv -----
`default_nettype none
module skac_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [skac_pkg::SAMPLE_BITS-1:0]   sample_out_o,
  input wire logic [15:0]                        gain_meter_o,
  input wire logic                               block_end_out_o
);

  // a taken sample keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input reopened too soon after a word was taken");

  // a new result appears only as the sequencer returns to idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while the input is still closed");

  // a word taken while no result is shown does not produce a result straight away
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after a word was taken");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o)
      && $stable(gain_meter_o) && $stable(block_end_out_o))
    else $error("stalled result word changed");

endmodule

bind soft_knee_audio_compressor skac_checker u_skac_checker (.*);
`default_nettype wire

// ----- tb/tb_soft_knee_audio_compressor.sv -----
`timescale 1ns / 1ps
module tb_soft_knee_audio_compressor;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [skac_pkg::SAMPLE_BITS-1:0] sample;
    logic [15:0]                      gain;
    logic                             block_end;
  } gained_word_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [skac_pkg::SAMPLE_BITS-1:0] sample_in_i;
  logic                             block_end_in_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic [skac_pkg::SAMPLE_BITS-1:0] sample_out_o;
  logic [15:0]                      gain_meter_o;
  logic                             block_end_out_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [2:0]                       cfg_index_i;
  logic [15:0]                      cfg_data_i;

  soft_knee_audio_compressor i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_in_i, .block_end_in_i,
    .out_valid_o, .out_stall_i, .sample_out_o, .gain_meter_o, .block_end_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // expected gained words, oldest first
  gained_word_t gained_q[$];
  int           n_errors;
  bit           idle_on;
  int           stall_cnt;

  // predictor state
  longint unsigned log2_frac_tab [skac_pkg::LOG_SIZE];
  longint unsigned pow2_step_tab [skac_pkg::EXP_STEPS];
  longint unsigned env_mag;
  logic [15:0] thr_r, kinv_r, slope_r, att_r, rel_r;
  logic [12:0] kw_r;
  logic [13:0] mk_r;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n_in);
    longint unsigned n, root, b;
    n    = n_in;
    root = 0;
    b    = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n    = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic build_curve_tabs();
    longint unsigned m;
    longint unsigned r;
    for (int i = 0; i < skac_pkg::LOG_SIZE; i++) begin
      m = longint'(skac_pkg::LOG_SIZE + i) << (30 - skac_pkg::LOG_TABLE_BITS);
      r = 0;
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r = r | (64'd1 << k);
        end
      end
      log2_frac_tab[i] = r;
    end
    pow2_step_tab[0] = int_sqrt(64'd2 << 60);
    for (int k = 1; k < skac_pkg::EXP_STEPS; k++)
      pow2_step_tab[k] = int_sqrt(pow2_step_tab[k-1] << 30);
  endtask

  task automatic reset_model();
    thr_r   = 16'hEC00;
    kw_r    = 13'd1536;
    kinv_r  = 16'd43690;
    slope_r = 16'd49152;
    mk_r    = 14'd0;
    att_r   = 16'd64880;
    rel_r   = 16'd65470;
    env_mag = 0;
  endtask

  function automatic longint clamp_q88(input longint v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  // envelope in dB, Q8.8, full scale = 0 dB
  function automatic longint env_level_db(input longint unsigned env);
    int              p;
    longint unsigned idx;
    longint          l2;
    if (env == 0) return -32768;
    p = 0;
    while (p < 63 && (env >> (p + 1)) != 0) p++;
    idx = (p >= skac_pkg::LOG_TABLE_BITS) ? env >> (p - skac_pkg::LOG_TABLE_BITS)
                                          : env << (skac_pkg::LOG_TABLE_BITS - p);
    idx = idx & (skac_pkg::LOG_SIZE - 1);
    l2  = longint'(p) * 65536 + longint'(log2_frac_tab[idx])
          - longint'(skac_pkg::SAMPLE_BITS - 1) * 65536;
    return clamp_q88((l2 * skac_pkg::DB_PER_LOG2 + (64'sd1 <<< 23)) >>> 24);
  endfunction

  // soft-knee gain reduction in Q8.8
  function automatic longint knee_reduction(input longint in_db);
    longint thr, half, kstart, kend, excess, t, prog;
    thr    = longint'($signed(thr_r));
    half   = longint'(kw_r >> 1);
    kstart = thr - half;
    kend   = thr + half;
    excess = in_db - thr;
    if (in_db > kend) return (excess * longint'(slope_r)) >>> 16;
    if (in_db > kstart) begin
      prog = ((in_db - kstart) * longint'(kinv_r)) >>> 10;
      if (prog > 65536) prog = 65536;
      t = excess * longint'(slope_r);
      t = (t * prog) >>> 16;
      t = (t * prog) >>> 16;
      return t >>> 16;
    end
    return 0;
  endfunction

  function automatic gained_word_t compress_sample(
      input logic [skac_pkg::SAMPLE_BITS-1:0] s, input logic be);
    gained_word_t    w;
    longint          x, gain, e2, ip, frac, y;
    longint unsigned mag, coeff, m, prod;
    x     = longint'($signed(s));
    mag   = (x < 0) ? longint'(-x) : x;
    coeff = (mag > env_mag) ? att_r : rel_r;
    if (env_mag >= mag) env_mag = mag + (((env_mag - mag) * coeff) >> 16);
    else env_mag = mag - (((mag - env_mag) * coeff) >> 16);
    gain = clamp_q88(longint'($signed(mk_r)) - knee_reduction(env_level_db(env_mag)));
    e2   = (gain * skac_pkg::LOG2_PER_DB) >>> 16;
    ip   = e2 >>> 16;
    frac = e2 - ip * 65536;
    m    = 64'd1 << 30;
    for (int k = 0; k < skac_pkg::EXP_STEPS; k++)
      if ((frac >> (15 - k)) & 1) m = (m * pow2_step_tab[k]) >> 30;
    prod = mag * m;
    if (30 - ip >= 63) prod = 0;
    else prod = prod >> (30 - ip);
    if (prod > (64'd1 << (skac_pkg::SAMPLE_BITS - 1)))
      prod = 64'd1 << (skac_pkg::SAMPLE_BITS - 1);
    y = (x < 0) ? -longint'(prod) : longint'(prod);
    if (y > (64'sd1 <<< (skac_pkg::SAMPLE_BITS - 1)) - 1)
      y = (64'sd1 <<< (skac_pkg::SAMPLE_BITS - 1)) - 1;
    w.sample    = y[skac_pkg::SAMPLE_BITS-1:0];
    w.gain      = gain[15:0];
    w.block_end = be;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    n_errors++;
  endtask

  // send one sample word; valid stays high across back-to-back words
  task automatic send_sample(input logic [skac_pkg::SAMPLE_BITS-1:0] s, input logic be);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_in_i    <= s;
    block_end_in_i <= be;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gained_q.push_back(compress_sample(s, be));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    while (gained_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    end_burst();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      skac_pkg::CFG_THRESHOLD: thr_r   = val;
      skac_pkg::CFG_KNEE_W:    kw_r    = val[12:0];
      skac_pkg::CFG_KNEE_INV:  kinv_r  = val;
      skac_pkg::CFG_SLOPE:     slope_r = val;
      skac_pkg::CFG_MAKEUP:    mk_r    = val[13:0];
      skac_pkg::CFG_ATTACK:    att_r   = val;
      skac_pkg::CFG_RELEASE:   rel_r   = val;
      default: ;
    endcase
  endtask

  function automatic logic [skac_pkg::SAMPLE_BITS-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: return r[skac_pkg::SAMPLE_BITS-1:0];
      1: return skac_pkg::SAMPLE_BITS'($signed(r) >>> (8 + $urandom_range(23)));
      2: return $urandom_range(1) ? skac_pkg::SAMPLE_BITS'(24'h7FFFFF - $urandom_range(3))
                                  : skac_pkg::SAMPLE_BITS'(24'h800000 + $urandom_range(3));
      default: return skac_pkg::SAMPLE_BITS'($signed(r) >>> 8 + $urandom_range(6));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(24'h000000, 1'b0);  // zero envelope
    send_sample(24'h000000, 1'b1);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h123456, 1'b1);
    send_sample(24'hA5A5A5, 1'b0);
    send_sample(24'h000000, 1'b0);
  endtask

  task automatic test_register_extremes();
    // no knee, full slope, attack follows instantly
    write_reg(skac_pkg::CFG_KNEE_W, 16'd0);
    write_reg(skac_pkg::CFG_SLOPE, 16'hFFFF);
    write_reg(skac_pkg::CFG_ATTACK, 16'd0);
    write_reg(skac_pkg::CFG_RELEASE, 16'd0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h040000, 1'b1);
    // wide knee, inconsistent inverse clamps progress
    write_reg(skac_pkg::CFG_THRESHOLD, 16'd0);
    write_reg(skac_pkg::CFG_KNEE_W, 16'd6144);
    write_reg(skac_pkg::CFG_KNEE_INV, 16'hFFFF);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h200000, 1'b0);
    write_reg(skac_pkg::CFG_KNEE_INV, 16'd0);
    send_sample(24'h400000, 1'b1);
    // gain saturates low; unused bits ignored
    write_reg(skac_pkg::CFG_THRESHOLD, 16'h8000);
    write_reg(skac_pkg::CFG_MAKEUP, 16'hE800);
    send_sample(24'h7FFFFF, 1'b0);
    write_reg(skac_pkg::CFG_THRESHOLD, 16'h7FFF);
    write_reg(skac_pkg::CFG_MAKEUP, 16'hD800);  // 6144 with junk upper bits
    send_sample(24'h000100, 1'b0);
    send_sample(24'hFFFF00, 1'b1);
    write_reg(skac_pkg::CFG_THRESHOLD, 16'hA000);
    write_reg(skac_pkg::CFG_SLOPE, 16'd0);
    write_reg(skac_pkg::CFG_KNEE_W, 16'hFFFF);
    write_reg(skac_pkg::CFG_ATTACK, 16'hFFFF);
    write_reg(skac_pkg::CFG_RELEASE, 16'hFFFF);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h000000, 1'b1);
  endtask

  task automatic test_random_traffic();
    int n;
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 3);
      if (ph == 0) begin
        // back to reset values
        write_reg(skac_pkg::CFG_THRESHOLD, 16'hEC00);
        write_reg(skac_pkg::CFG_KNEE_W, 16'd1536);
        write_reg(skac_pkg::CFG_KNEE_INV, 16'd43690);
        write_reg(skac_pkg::CFG_SLOPE, 16'd49152);
        write_reg(skac_pkg::CFG_MAKEUP, 16'd0);
        write_reg(skac_pkg::CFG_ATTACK, 16'd64880);
        write_reg(skac_pkg::CFG_RELEASE, 16'd65470);
      end else begin
        write_reg(skac_pkg::CFG_THRESHOLD,
                  $urandom_range(1) ? 16'($urandom) : -16'($urandom_range(24576)));
        write_reg(skac_pkg::CFG_KNEE_W,
                  $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(6144)));
        write_reg(skac_pkg::CFG_KNEE_INV, 16'($urandom));
        write_reg(skac_pkg::CFG_SLOPE, 16'($urandom));
        write_reg(skac_pkg::CFG_MAKEUP, $urandom_range(1) ? 16'($urandom)
                                          : 16'($urandom_range(12288) - 6144));
        write_reg(skac_pkg::CFG_ATTACK, $urandom_range(1) ? 16'($urandom)
                                          : 16'(65535 - $urandom_range(2000)));
        write_reg(skac_pkg::CFG_RELEASE, $urandom_range(1) ? 16'($urandom)
                                           : 16'(65535 - $urandom_range(500)));
      end
      n = 200;
      for (int i = 0; i < n; i++) begin
        if (ph == 5 && i == 100) end_burst();  // sender holds until all words return
        send_sample(rand_sample(), 1'($urandom_range(7) == 0));
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    gained_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gained_q.size() == 0) begin
        report_mismatch("unexpected word", sample_out_o, 0);
      end else begin
        want = gained_q.pop_front();
        if (sample_out_o !== want.sample) report_mismatch("sample_out", sample_out_o, want.sample);
        if (gain_meter_o !== want.gain) report_mismatch("gain_meter", gain_meter_o, want.gain);
        if (block_end_out_o !== want.block_end)
          report_mismatch("block_end_out", block_end_out_o, want.block_end);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 30);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("tb_soft_knee_audio_compressor NOT OK");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_in_i    = '0;
    block_end_in_i = 1'b0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = skac_pkg::CFG_THRESHOLD;
    cfg_data_i     = '0;
    n_errors       = 0;
    stall_cnt      = 0;
    idle_on        = 1'b1;
    build_curve_tabs();
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    end_burst();
    if (gained_q.size() != 0) report_mismatch("words left over", gained_q.size(), 0);
    if (n_errors == 0) begin
      $display("tb_soft_knee_audio_compressor OK");
    end else begin
      $display("tb_soft_knee_audio_compressor NOT OK");
    end
    $finish;
  end

endmodule
